>>> design/tpes_pkg.sv
`timescale 1ns / 1ps

package tpes_pkg;

    // Field and datapath widths.
    localparam int DATA_W    = 16;
    localparam int SUM_W     = 18;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int GAIN_FRAC = 12;

    // Number of phases handled per word.
    localparam int PHASES  = 3;
    localparam int PHASE_W = 2;

    // Default depth of the sum history ring.
    localparam int HISTORY_DEPTH_DEF = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_A        = 3'd0,
        CFG_GAIN_B        = 3'd1,
        CFG_GAIN_C        = 3'd2,
        CFG_SUM_CAP       = 3'd3,
        CFG_WIDTH_FLOOR   = 3'd4,
        CFG_START_COUNT   = 3'd5,
        CFG_OVERLAP_COUNT = 3'd6
    } cfg_addr_t;

    // Phase indexes used by the ordering logic.
    localparam logic [PHASE_W-1:0] PH_A = 2'd0;
    localparam logic [PHASE_W-1:0] PH_B = 2'd1;
    localparam logic [PHASE_W-1:0] PH_C = 2'd2;

    // Register reset values.
    localparam logic [DATA_W-1:0] GAIN_RST    = 16'd4096;
    localparam logic [DATA_W-1:0] LIMIT_RST   = 16'hFFFF;
    localparam logic [DATA_W-1:0] FLOOR_RST   = 16'd0;
    localparam logic [DATA_W-1:0] START_RST   = 16'd0;
    localparam logic [DATA_W-1:0] OVERLAP_RST = 16'd0;

    // Control and status between the sequencer and a divider lane.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
    } div_stat_t;

endpackage

>>> design/tpes_divider.sv
`timescale 1ns / 1ps

module tpes_divider
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tpes_pkg::div_ctrl_t                ctrl,
    input  logic [tpes_pkg::PROD_W-1:0]        dividend,
    input  logic [tpes_pkg::SUM_W-1:0]         divisor,
    output logic [tpes_pkg::DATA_W-1:0]        quotient,
    output tpes_pkg::div_stat_t                stat
);

    localparam int CNT_W = $clog2(tpes_pkg::DATA_W + 1);

    logic                            busy_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [tpes_pkg::SUM_W-1:0]      rem_reg;
    logic [tpes_pkg::SUM_W-1:0]      rem_next;
    logic [tpes_pkg::DATA_W-1:0]     quo_reg;
    logic [tpes_pkg::DATA_W-1:0]     quo_next;
    logic [tpes_pkg::SUM_W:0]        trial;
    logic [tpes_pkg::SUM_W:0]        divisor_ext;
    logic [tpes_pkg::SUM_W-1:0]      divisor_reg;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial       = {rem_reg, quo_reg[tpes_pkg::DATA_W-1]};
        divisor_ext = {1'b0, divisor_reg};
        if (trial >= divisor_ext)
        begin
            rem_next = tpes_pkg::SUM_W'(trial - divisor_ext);
            quo_next = {quo_reg[tpes_pkg::DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[tpes_pkg::SUM_W-1:0];
            quo_next = {quo_reg[tpes_pkg::DATA_W-2:0], 1'b0};
        end
    end

    // Step counter; the quotient is known to fit in DATA_W bits, so the
    // upper dividend half is loaded straight into the remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(tpes_pkg::DATA_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and shifting dividend/quotient word.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg     <= tpes_pkg::SUM_W'(dividend[tpes_pkg::PROD_W-1:tpes_pkg::DATA_W]);
            quo_reg     <= dividend[tpes_pkg::DATA_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;

endmodule

>>> design/tpes_history.sv
`timescale 1ns / 1ps

module tpes_history
#(
    parameter int HISTORY_DEPTH = tpes_pkg::HISTORY_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [tpes_pkg::SUM_W-1:0]    data,
    output logic                          full
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);

    logic [tpes_pkg::SUM_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [PTR_W-1:0]           ptr_reg;
    logic                       wrapped_reg;

    // Ring storage, written at the current slot.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hist_mem[ptr_reg] <= data;
        end
    end

    // Slot pointer; the full flag stays set once the ring has wrapped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (push)
        begin
            if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
            begin
                ptr_reg     <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
        end
    end

    assign full = wrapped_reg;

endmodule

>>> design/three_phase_pwm_edge_sequencer_core.sv
`timescale 1ns / 1ps

// Three-phase PWM edge sequencer. Each input word carries three phase demands;
// each is scaled by its Q4.12 gain into a width saturated to 16 bits, the
// unscaled width sum is logged in a ring of HISTORY_DEPTH entries, widths are
// rescaled by the sum cap over the sum when the sum exceeds the cap, and the
// phases are placed back to back from shortest to longest, returning one word
// of on/off compare values. One word is in work at a time: it passes the
// multiply, sum, scale, divide, sort and place states, and the divide state
// waits only when rescaling is needed, for the bit-per-cycle dividers (one
// per phase, run in parallel). A result is loaded once the output register is
// free, and the next word can be taken in the cycle after. A new word is
// accepted while the previous result waits in the output register.
// Configuration writes take effect at once and must be made while the block
// is idle.
module three_phase_pwm_edge_sequencer_core
#(
    parameter int HISTORY_DEPTH = tpes_pkg::HISTORY_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_en,
    input  logic [tpes_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tpes_pkg::DATA_W-1:0]        cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tpes_pkg::DATA_W-1:0]        demand_a,
    input  logic [tpes_pkg::DATA_W-1:0]        demand_b,
    input  logic [tpes_pkg::DATA_W-1:0]        demand_c,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tpes_pkg::DATA_W-1:0]        on_a,
    output logic [tpes_pkg::DATA_W-1:0]        off_a,
    output logic [tpes_pkg::DATA_W-1:0]        on_b,
    output logic [tpes_pkg::DATA_W-1:0]        off_b,
    output logic [tpes_pkg::DATA_W-1:0]        on_c,
    output logic [tpes_pkg::DATA_W-1:0]        off_c,
    output logic [tpes_pkg::SUM_W-1:0]         width_sum,
    output logic                               history_full
);

    localparam int DW = tpes_pkg::DATA_W;
    localparam int SW = tpes_pkg::SUM_W;
    localparam int PW = tpes_pkg::PROD_W;
    localparam int NP = tpes_pkg::PHASES;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_SUM   = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_SORT  = 7'b0100000,
        S_PLACE = 7'b1000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [DW-1:0] gain_reg [NP];
    logic [DW-1:0] limit_reg;
    logic [DW-1:0] floor_reg;
    logic [DW-1:0] start_reg;
    logic [DW-1:0] overlap_reg;

    // Datapath registers.
    logic [DW-1:0] demand_reg [NP];
    logic [PW-1:0] prod_reg [NP];
    logic [DW-1:0] width_reg [NP];
    logic [SW-1:0] sum_reg;
    logic          over_reg;
    logic [DW-1:0] ow_reg [NP];
    logic [tpes_pkg::PHASE_W-1:0] ord_reg [NP];
    logic          supp_reg;

    // Output register.
    logic          out_valid_reg;
    logic [DW-1:0] on_reg [NP];
    logic [DW-1:0] off_reg [NP];
    logic [SW-1:0] sum_out_reg;
    logic          full_out_reg;

    // Combinational helpers.
    logic [DW-1:0] width_sat [NP];
    logic [SW-1:0] sum_next;
    logic          over_now;
    logic [PW-1:0] dividend [NP];
    logic [DW-1:0] quotient [NP];
    tpes_pkg::div_ctrl_t div_ctrl;
    tpes_pkg::div_stat_t div_stat [NP];
    logic          div_busy;
    logic [tpes_pkg::PHASE_W-1:0] ord_next [NP];
    logic [DW-1:0] on_p [NP];
    logic [DW-1:0] off_p [NP];
    logic [DW-1:0] on_k [NP];
    logic [DW-1:0] off_k [NP];
    logic          in_fire;
    logic          out_free;
    logic          hist_full;
    logic [SW:0]   scaled_sum;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0] <= tpes_pkg::GAIN_RST;
            gain_reg[1] <= tpes_pkg::GAIN_RST;
            gain_reg[2] <= tpes_pkg::GAIN_RST;
            limit_reg   <= tpes_pkg::LIMIT_RST;
            floor_reg   <= tpes_pkg::FLOOR_RST;
            start_reg   <= tpes_pkg::START_RST;
            overlap_reg <= tpes_pkg::OVERLAP_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                tpes_pkg::CFG_GAIN_A:        gain_reg[0] <= cfg_data;
                tpes_pkg::CFG_GAIN_B:        gain_reg[1] <= cfg_data;
                tpes_pkg::CFG_GAIN_C:        gain_reg[2] <= cfg_data;
                tpes_pkg::CFG_SUM_CAP:       limit_reg   <= cfg_data;
                tpes_pkg::CFG_WIDTH_FLOOR:   floor_reg   <= cfg_data;
                tpes_pkg::CFG_START_COUNT:   start_reg   <= cfg_data;
                tpes_pkg::CFG_OVERLAP_COUNT: overlap_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Width saturation, width sum and the over-limit test.
    always_comb
    begin
        for (int k = 0; k < NP; k++)
        begin
            if (|prod_reg[k][PW-1:DW+tpes_pkg::GAIN_FRAC])
            begin
                width_sat[k] = '1;
            end
            else
            begin
                width_sat[k] = prod_reg[k][DW+tpes_pkg::GAIN_FRAC-1:tpes_pkg::GAIN_FRAC];
            end
            dividend[k] = PW'(width_reg[k]) * PW'(limit_reg);
        end
        sum_next = SW'(width_sat[0]) + SW'(width_sat[1]) + SW'(width_sat[2]);
        over_now = (sum_reg > SW'(limit_reg));
    end

    assign div_ctrl.start = (state_reg == S_SCALE) && over_now;
    assign div_busy       = div_stat[0].busy || div_stat[1].busy || div_stat[2].busy;

    // One divider lane per phase, all sharing the width sum as divisor.
    for (genvar g = 0; g < NP; g++)
    begin : g_div
        tpes_divider u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (div_ctrl),
            .dividend (dividend[g]),
            .divisor  (sum_reg),
            .quotient (quotient[g]),
            .stat     (div_stat[g])
        );
    end

    tpes_history
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_history
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (state_reg == S_SUM),
        .data  (sum_next),
        .full  (hist_full)
    );

    // Ordering tree; strict compares send ties to the later branches.
    always_comb
    begin
        if (width_reg[0] < width_reg[1])
        begin
            if (width_reg[1] < width_reg[2])
            begin
                ord_next[0] = tpes_pkg::PH_A;
                ord_next[1] = tpes_pkg::PH_B;
                ord_next[2] = tpes_pkg::PH_C;
            end
            else if (width_reg[0] < width_reg[2])
            begin
                ord_next[0] = tpes_pkg::PH_A;
                ord_next[1] = tpes_pkg::PH_C;
                ord_next[2] = tpes_pkg::PH_B;
            end
            else
            begin
                ord_next[0] = tpes_pkg::PH_C;
                ord_next[1] = tpes_pkg::PH_A;
                ord_next[2] = tpes_pkg::PH_B;
            end
        end
        else
        begin
            if (width_reg[0] < width_reg[2])
            begin
                ord_next[0] = tpes_pkg::PH_B;
                ord_next[1] = tpes_pkg::PH_A;
                ord_next[2] = tpes_pkg::PH_C;
            end
            else if (width_reg[1] < width_reg[2])
            begin
                ord_next[0] = tpes_pkg::PH_B;
                ord_next[1] = tpes_pkg::PH_C;
                ord_next[2] = tpes_pkg::PH_A;
            end
            else
            begin
                ord_next[0] = tpes_pkg::PH_C;
                ord_next[1] = tpes_pkg::PH_B;
                ord_next[2] = tpes_pkg::PH_A;
            end
        end
    end

    // Edge placement in pulse order, then mapped back to the phases.
    always_comb
    begin
        on_p[0] = start_reg;
        if (supp_reg)
        begin
            off_p[0] = start_reg;
            on_p[1]  = start_reg;
        end
        else
        begin
            off_p[0] = start_reg + ow_reg[0];
            on_p[1]  = off_p[0] - overlap_reg;
        end
        off_p[1] = on_p[1] + ow_reg[1];
        on_p[2]  = off_p[1] - overlap_reg;
        off_p[2] = on_p[2] + ow_reg[2];

        for (int k = 0; k < NP; k++)
        begin
            on_k[k]  = '0;
            off_k[k] = '0;
        end
        for (int p = 0; p < NP; p++)
        begin
            on_k[ord_reg[p]]  = on_p[p];
            off_k[ord_reg[p]] = off_p[p];
        end
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:   state_reg <= S_SUM;
                S_SUM:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (!over_reg || !div_busy)
                    begin
                        state_reg <= S_SORT;
                    end
                end
                S_SORT:  state_reg <= S_PLACE;
                S_PLACE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, loaded by state.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            demand_reg[0] <= demand_a;
            demand_reg[1] <= demand_b;
            demand_reg[2] <= demand_c;
        end
        for (int k = 0; k < NP; k++)
        begin
            if (state_reg == S_MUL)
            begin
                prod_reg[k] <= PW'(demand_reg[k]) * PW'(gain_reg[k]);
            end
            if (state_reg == S_SUM)
            begin
                width_reg[k] <= width_sat[k];
            end
            if ((state_reg == S_DIV) && over_reg && !div_busy)
            begin
                width_reg[k] <= quotient[k];
            end
            if (state_reg == S_SORT)
            begin
                ow_reg[k]  <= width_reg[ord_next[k]];
                ord_reg[k] <= ord_next[k];
            end
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_SCALE)
        begin
            over_reg <= over_now;
        end
        if (state_reg == S_SORT)
        begin
            supp_reg <= (width_reg[ord_next[0]] < floor_reg);
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_PLACE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register word.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PLACE) && out_free)
        begin
            for (int k = 0; k < NP; k++)
            begin
                on_reg[k]  <= on_k[k];
                off_reg[k] <= off_k[k];
            end
            sum_out_reg  <= sum_reg;
            full_out_reg <= hist_full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign on_a         = on_reg[0];
    assign off_a        = off_reg[0];
    assign on_b         = on_reg[1];
    assign off_b        = off_reg[1];
    assign on_c         = on_reg[2];
    assign off_c        = off_reg[2];
    assign width_sum    = sum_out_reg;
    assign history_full = full_out_reg;

    assign scaled_sum = (SW+1)'(width_reg[0]) + (SW+1)'(width_reg[1])
                      + (SW+1)'(width_reg[2]);

    // Rescaled widths never add up to more than the limit.
    a_scaled_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SORT) && over_reg) |-> (scaled_sum <= (SW+1)'(limit_reg)))
        else $error("rescaled widths exceed the width limit");

    // Pulse order is nondecreasing in width.
    a_order_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) |-> ((ow_reg[0] <= ow_reg[1]) && (ow_reg[1] <= ow_reg[2])))
        else $error("pulse order is not sorted by width");

    // A result never overwrites a word that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(width_sum)))
        else $error("pending result word was overwritten");

endmodule

>>> tb/sv/three_phase_pwm_edge_sequencer_core_tb.sv
`timescale 1ns / 1ps

module three_phase_pwm_edge_sequencer_core_tb;

    import tpes_pkg::*;

    localparam int RING_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int PHASE_COUNT  = 14;
    localparam int PHASE_WORDS  = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 3'd7;

    // One result word as the block presents it.
    typedef struct packed {
        logic [DATA_W-1:0] on_a;
        logic [DATA_W-1:0] off_a;
        logic [DATA_W-1:0] on_b;
        logic [DATA_W-1:0] off_b;
        logic [DATA_W-1:0] on_c;
        logic [DATA_W-1:0] off_c;
        logic [SUM_W-1:0]  width_sum;
        logic              history_full;
    } edges_t;

    // One row of the directed table: a register write or a demand word.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     data;
        logic [DATA_W-1:0]     dem_a;
        logic [DATA_W-1:0]     dem_b;
        logic [DATA_W-1:0]     dem_c;
        bit                    known;
        edges_t                want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0]     cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DATA_W-1:0]     demand_a = '0;
    logic [DATA_W-1:0]     demand_b = '0;
    logic [DATA_W-1:0]     demand_c = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DATA_W-1:0]     on_a;
    logic [DATA_W-1:0]     off_a;
    logic [DATA_W-1:0]     on_b;
    logic [DATA_W-1:0]     off_b;
    logic [DATA_W-1:0]     on_c;
    logic [DATA_W-1:0]     off_c;
    logic [SUM_W-1:0]      width_sum;
    logic                  history_full;

    // Shadow of the configuration and of the history ring position.
    logic [DATA_W-1:0] cfg_reg [7];
    int                ring_ptr;
    bit                ring_wrapped;

    edges_t pending_edges [$];
    edges_t got_edges;
    edges_t want_edges;

    int  words_sent;
    int  words_checked;
    int  fail_count;
    int  rescaled_words;
    int  suppressed_words;
    int  stall_left;
    int  hold_count;
    bit  hold_req;
    bit  hold_done;
    bit  quiet;
    step_t plan [$];

    three_phase_pwm_edge_sequencer_core #(
        .HISTORY_DEPTH (RING_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .demand_a     (demand_a),
        .demand_b     (demand_b),
        .demand_c     (demand_c),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .on_a         (on_a),
        .off_a        (off_a),
        .on_b         (on_b),
        .off_b        (off_b),
        .on_c         (on_c),
        .off_c        (off_c),
        .width_sum    (width_sum),
        .history_full (history_full)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the compare values of one word and advance the ring position.
    function automatic edges_t predict_edges(input logic [DATA_W-1:0] da,
                                             input logic [DATA_W-1:0] db,
                                             input logic [DATA_W-1:0] dc);
        logic [DATA_W-1:0] dem [3];
        logic [DATA_W-1:0] gain [3];
        logic [DATA_W-1:0] w [3];
        logic [DATA_W-1:0] on_v [3];
        logic [DATA_W-1:0] off_v [3];
        logic [PHASE_W-1:0] ord [3];
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0] total;
        logic [DATA_W-1:0] limit;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] gap;
        edges_t r;
        dem[0] = da;
        dem[1] = db;
        dem[2] = dc;
        gain[0] = cfg_reg[CFG_GAIN_A];
        gain[1] = cfg_reg[CFG_GAIN_B];
        gain[2] = cfg_reg[CFG_GAIN_C];
        limit = cfg_reg[CFG_SUM_CAP];
        start = cfg_reg[CFG_START_COUNT];
        gap = cfg_reg[CFG_OVERLAP_COUNT];

        // Q4.12 scaling, floor, then saturation to 16 bits.
        for (int k = 0; k < PHASES; k++)
        begin
            prod = PROD_W'(dem[k]) * PROD_W'(gain[k]);
            w[k] = (prod[PROD_W-1:GAIN_FRAC] > 20'hFFFF)
                 ? 16'hFFFF
                 : prod[GAIN_FRAC+DATA_W-1:GAIN_FRAC];
        end
        total = SUM_W'(w[0]) + SUM_W'(w[1]) + SUM_W'(w[2]);

        // The unscaled sum goes into the ring; the flag sticks once it wraps.
        ring_ptr++;
        if (ring_ptr >= RING_DEPTH)
        begin
            ring_ptr = 0;
            ring_wrapped = 1'b1;
        end

        // Rescale all widths when the sum is over the limit.
        if (total > SUM_W'(limit))
        begin
            rescaled_words++;
            for (int k = 0; k < PHASES; k++)
                w[k] = DATA_W'((64'(w[k]) * 64'(limit)) / 64'(total));
        end

        // Ordering tree with strict compares, so ties fall to later branches.
        if (w[0] < w[1])
        begin
            if (w[1] < w[2])
                ord = '{PH_A, PH_B, PH_C};
            else if (w[0] < w[2])
                ord = '{PH_A, PH_C, PH_B};
            else
                ord = '{PH_C, PH_A, PH_B};
        end
        else
        begin
            if (w[0] < w[2])
                ord = '{PH_B, PH_A, PH_C};
            else if (w[1] < w[2])
                ord = '{PH_B, PH_C, PH_A};
            else
                ord = '{PH_C, PH_B, PH_A};
        end

        // Place pulses back to back; a too short first pulse collapses.
        on_v[ord[0]] = start;
        if (w[ord[0]] < cfg_reg[CFG_WIDTH_FLOOR])
        begin
            suppressed_words++;
            off_v[ord[0]] = start;
            on_v[ord[1]] = start;
        end
        else
        begin
            off_v[ord[0]] = start + w[ord[0]];
            on_v[ord[1]] = off_v[ord[0]] - gap;
        end
        off_v[ord[1]] = on_v[ord[1]] + w[ord[1]];
        on_v[ord[2]] = off_v[ord[1]] - gap;
        off_v[ord[2]] = on_v[ord[2]] + w[ord[2]];

        r.on_a = on_v[PH_A];
        r.off_a = off_v[PH_A];
        r.on_b = on_v[PH_B];
        r.off_b = off_v[PH_B];
        r.on_c = on_v[PH_C];
        r.off_c = off_v[PH_C];
        r.width_sum = total;
        r.history_full = ring_wrapped;
        return r;
    endfunction

    function automatic step_t word_row(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b,
                                       input logic [DATA_W-1:0] c);
        step_t s;
        s = '{default: '0};
        s.dem_a = a;
        s.dem_b = b;
        s.dem_c = c;
        return s;
    endfunction

    function automatic step_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] data);
        step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.addr = addr;
        s.data = data;
        return s;
    endfunction

    function automatic step_t known_row(input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b,
                                        input logic [DATA_W-1:0] c,
                                        input edges_t want);
        step_t s;
        s = word_row(a, b, c);
        s.known = 1'b1;
        s.want = want;
        return s;
    endfunction

    // Register value for a random phase, with the extremes well represented.
    function automatic logic [DATA_W-1:0] pick_setting(input cfg_addr_t idx);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'h0000;
        if (roll == 1)
            return 16'hFFFF;
        if (roll == 2)
            return DATA_W'($urandom);
        case (idx)
            CFG_GAIN_A, CFG_GAIN_B, CFG_GAIN_C:
                return DATA_W'($urandom_range(2048, 8192));
            CFG_SUM_CAP:       return DATA_W'($urandom_range(1000, 65535));
            CFG_WIDTH_FLOOR:   return DATA_W'($urandom_range(0, 3000));
            CFG_OVERLAP_COUNT: return DATA_W'($urandom_range(0, 1500));
            default:           return DATA_W'($urandom);
        endcase
    endfunction

    // Demand mix: full range, ties, small values and zeros.
    task automatic pick_demands(output logic [DATA_W-1:0] a,
                                output logic [DATA_W-1:0] b,
                                output logic [DATA_W-1:0] c);
        int mode;
        mode = $urandom_range(0, 9);
        a = DATA_W'($urandom_range(0, 20000));
        b = DATA_W'($urandom_range(0, 20000));
        c = DATA_W'($urandom_range(0, 20000));
        case (mode)
            0, 1, 2:
            begin
                a = DATA_W'($urandom);
                b = DATA_W'($urandom);
                c = DATA_W'($urandom);
            end
            3:
            begin
                b = a;
                c = a;
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0: b = a;
                    1: c = a;
                    default: c = b;
                endcase
            end
            5:
            begin
                a = DATA_W'($urandom_range(0, 1000));
                b = DATA_W'($urandom_range(0, 1000));
            end
            6:
            begin
                case ($urandom_range(0, 2))
                    0: a = '0;
                    1: b = '0;
                    default: c = '0;
                endcase
            end
            default: ;
        endcase
    endtask

    // One register write; the caller lowers cfg_en after the last one.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        cfg_en <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        if (addr <= CFG_OVERLAP_COUNT)
            cfg_reg[addr] = data;
        @(posedge clk);
    endtask

    // Offer one word and hold it until accepted; valid stays up afterwards.
    task automatic send_word(input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b,
                             input logic [DATA_W-1:0] c,
                             input bit known,
                             input edges_t known_want);
        edges_t want;
        in_valid <= 1'b1;
        demand_a <= a;
        demand_b <= b;
        demand_c <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_edges(a, b, c);
        pending_edges.push_back(known ? known_want : want);
        words_sent++;
    endtask

    // Let every word in flight come out before touching the registers.
    task automatic drain_words();
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, one long hold-off, none at the end.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
        end
        else
            out_ready <= 1'b1;
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_edges = {on_a, off_a, on_b, off_b, on_c, off_c, width_sum, history_full};
            if (pending_edges.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result word: ", $realtime,
                             "on_a=%0d off_a=%0d ", got_edges.on_a, got_edges.off_a,
                             "on_b=%0d off_b=%0d ", got_edges.on_b, got_edges.off_b,
                             "on_c=%0d off_c=%0d ", got_edges.on_c, got_edges.off_c,
                             "sum=%0d full=%0d", got_edges.width_sum,
                             got_edges.history_full);
            end
            else
            begin
                want_edges = pending_edges.pop_front();
                words_checked++;
                if (got_edges.on_a !== want_edges.on_a || got_edges.off_a !== want_edges.off_a
                    || got_edges.on_b !== want_edges.on_b || got_edges.off_b !== want_edges.off_b
                    || got_edges.on_c !== want_edges.on_c || got_edges.off_c !== want_edges.off_c
                    || got_edges.width_sum !== want_edges.width_sum
                    || got_edges.history_full !== want_edges.history_full)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("[%0t] result word %0d mismatch", $realtime, words_checked);
                        $display("  expected: ",
                                 "on_a=%0d off_a=%0d ", want_edges.on_a, want_edges.off_a,
                                 "on_b=%0d off_b=%0d ", want_edges.on_b, want_edges.off_b,
                                 "on_c=%0d off_c=%0d ", want_edges.on_c, want_edges.off_c,
                                 "sum=%0d full=%0d", want_edges.width_sum,
                                 want_edges.history_full);
                        $display("  actual:   ",
                                 "on_a=%0d off_a=%0d ", got_edges.on_a, got_edges.off_a,
                                 "on_b=%0d off_b=%0d ", got_edges.on_b, got_edges.off_b,
                                 "on_c=%0d off_c=%0d ", got_edges.on_c, got_edges.off_c,
                                 "sum=%0d full=%0d", got_edges.width_sum,
                                 got_edges.history_full);
                    end
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        logic [DATA_W-1:0] da;
        logic [DATA_W-1:0] db;
        logic [DATA_W-1:0] dc;
        logic [DATA_W-1:0] val;
        edges_t none;

        none = '0;
        cfg_reg[CFG_GAIN_A] = GAIN_RST;
        cfg_reg[CFG_GAIN_B] = GAIN_RST;
        cfg_reg[CFG_GAIN_C] = GAIN_RST;
        cfg_reg[CFG_SUM_CAP] = LIMIT_RST;
        cfg_reg[CFG_WIDTH_FLOOR] = FLOOR_RST;
        cfg_reg[CFG_START_COUNT] = START_RST;
        cfg_reg[CFG_OVERLAP_COUNT] = OVERLAP_RST;
        ring_ptr = 0;
        ring_wrapped = 1'b0;
        words_sent = 0;
        words_checked = 0;
        fail_count = 0;
        rescaled_words = 0;
        suppressed_words = 0;
        stall_left = 0;
        hold_count = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        quiet = 1'b0;

        plan = '{
            // Reset settings: zeros, a plain ascending case, full scale.
            known_row(16'd0, 16'd0, 16'd0, '0),
            known_row(16'd100, 16'd200, 16'd300,
                      '{16'd0, 16'd100, 16'd100, 16'd300, 16'd300, 16'd600, 18'd600, 1'b0}),
            known_row(16'hFFFF, 16'hFFFF, 16'hFFFF,
                      '{16'd43690, 16'd65535, 16'd21845, 16'd43690, 16'd0, 16'd21845,
                        18'd196605, 1'b0}),
            // The remaining branches of the ordering tree, then ties.
            word_row(16'd1, 16'd3, 16'd2),
            word_row(16'd3, 16'd1, 16'd2),
            word_row(16'd2, 16'd3, 16'd1),
            word_row(16'd2, 16'd1, 16'd3),
            word_row(16'd3, 16'd2, 16'd1),
            word_row(16'd5, 16'd5, 16'd7),
            word_row(16'd5, 16'd7, 16'd5),
            word_row(16'd7, 16'd5, 16'd5),
            // Gain extremes: saturation, zero gain, the smallest nonzero gain.
            cfg_row(CFG_GAIN_A, 16'hFFFF),
            cfg_row(CFG_GAIN_B, 16'h0000),
            cfg_row(CFG_GAIN_C, 16'h0001),
            word_row(16'hFFFF, 16'hFFFF, 16'hFFFF),
            word_row(16'd4095, 16'd1234, 16'd4096),
            // Short first pulse, overlap and compare wrap past 2^16.
            cfg_row(CFG_GAIN_A, GAIN_RST),
            cfg_row(CFG_GAIN_B, GAIN_RST),
            cfg_row(CFG_GAIN_C, GAIN_RST),
            cfg_row(CFG_WIDTH_FLOOR, 16'd1000),
            cfg_row(CFG_START_COUNT, 16'd65000),
            cfg_row(CFG_OVERLAP_COUNT, 16'd300),
            word_row(16'd500, 16'd2000, 16'd3000),
            word_row(16'd1500, 16'd2000, 16'd3000),
            word_row(16'd999, 16'd999, 16'd999),
            // Zero limit: any nonzero sum scales every width to zero.
            cfg_row(CFG_SUM_CAP, 16'h0000),
            word_row(16'd10, 16'd20, 16'd30),
            word_row(16'd0, 16'd0, 16'd0),
            // Largest overlap wraps: each next pulse starts one count after the previous off.
            cfg_row(CFG_SUM_CAP, 16'hFFFF),
            cfg_row(CFG_WIDTH_FLOOR, 16'h0000),
            cfg_row(CFG_START_COUNT, 16'h0000),
            cfg_row(CFG_OVERLAP_COUNT, 16'hFFFF),
            word_row(16'd40000, 16'd30000, 16'd20000),
            // A write past the last register changes nothing.
            cfg_row(CFG_NO_REG, 16'hFFFF),
            word_row(16'd1, 16'd2, 16'd3)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                if (!cfg_en)
                    drain_words();
                write_reg(plan[i].addr, plan[i].data);
            end
            else
            begin
                if (cfg_en)
                    cfg_en <= 1'b0;
                send_word(plan[i].dem_a, plan[i].dem_b, plan[i].dem_c,
                          plan[i].known, plan[i].want);
            end
        end

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain_words();
            for (int r = CFG_GAIN_A; r <= CFG_OVERLAP_COUNT; r++)
            begin
                if (ph == 0)
                    val = 16'hFFFF;
                else if (ph == 1)
                    val = 16'h0000;
                else
                    val = pick_setting(cfg_addr_t'(r));
                write_reg(CFG_ADDR_W'(r), val);
            end
            write_reg(CFG_NO_REG, DATA_W'($urandom));
            cfg_en <= 1'b0;

            if (ph == 3)
                hold_req = 1'b1;
            if (ph >= PHASE_COUNT - 2)
                quiet = 1'b1;

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick_demands(da, db, dc);
                send_word(da, db, dc, 1'b0, none);
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end

        // Let the last words drain, then watch for stray results.
        drain_words();
        repeat (40) @(posedge clk);

        $display("Sent %0d demand words, checked %0d result words over %0d register settings.",
                 words_sent, words_checked, PHASE_COUNT + 6);
        $display("Rescaled sums: %0d, suppressed first pulses: %0d, history wrapped: %0d.",
                 rescaled_words, suppressed_words, ring_wrapped);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d result words still expected.", pending_edges.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
